[hw/rtl/bdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int CNT_W   = 22;
  localparam int RES_W   = 9;   // year remainder in the 400-year cycle
  localparam int VSUM_W  = 10;  // weekday sum before mod 7
  localparam int IN_W    = 48;
  localparam int OUT_W   = 24;
  localparam int UPC_W   = 3;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [YEAR_W-1:0] YEAR_CYCLE = YEAR_W'(400);
  localparam logic [RES_W-1:0]  RES_LAST   = RES_W'(399);
  localparam logic [2:0]        WD_FRI     = 3'd5;
  localparam logic [2:0]        WD_SAT     = 3'd6;
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // Datapath operation selected by the control word
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_REDUCE,
    OP_CHECK,
    OP_STEP,
    OP_EMIT
  } op_t;

  // Branch condition selected by the control word
  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_REDUCED,
    COND_VALID,
    COND_IN_RANGE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] tgt_true;
    logic [UPC_W-1:0] tgt_false;
  } ucode_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic accept;
    logic reduced;
    logic valid;
    logic in_range;
    logic out_free;
  } flags_t;

  // Leap year from the year's remainder modulo 400
  function automatic logic is_leap(input logic [RES_W-1:0] r);
    logic cent;
    cent = (r == RES_W'(100)) || (r == RES_W'(200)) || (r == RES_W'(300));
    return (r == '0) || ((r[1:0] == 2'b00) && !cent);
  endfunction

  // Month length, zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
      4'd2:    n = leap ? DAY_W'(29) : DAY_W'(28);
      default: n = '0;
    endcase
    return n;
  endfunction

  // (31 * mm) / 12 with March as mm = 1
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] t;
    case (m)
      4'd1:    t = DAY_W'(28);
      4'd2:    t = DAY_W'(31);
      4'd3:    t = DAY_W'(2);
      4'd4:    t = DAY_W'(5);
      4'd5:    t = DAY_W'(7);
      4'd6:    t = DAY_W'(10);
      4'd7:    t = DAY_W'(12);
      4'd8:    t = DAY_W'(15);
      4'd9:    t = DAY_W'(18);
      4'd10:   t = DAY_W'(20);
      4'd11:   t = DAY_W'(23);
      4'd12:   t = DAY_W'(25);
      default: t = '0;
    endcase
    return t;
  endfunction

  // x mod 7 by reciprocal 292/2048, quotient low by at most one
  function automatic logic [2:0] mod7(input logic [VSUM_W-1:0] x);
    logic [18:0]       p;
    logic [VSUM_W-1:0] q;
    logic [VSUM_W-1:0] r;
    p = 19'(x) * 19'd292;
    q = VSUM_W'(p[18:11]);
    r = x - VSUM_W'(q * VSUM_W'(7));
    return (r >= VSUM_W'(7)) ? 3'(r - VSUM_W'(7)) : r[2:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bdc_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdc_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bdc_pkg::flags_t flags,
  output bdc_pkg::op_t        op
);

  // Step addresses
  localparam logic [bdc_pkg::UPC_W-1:0] UPC_WAIT   = 3'd0;
  localparam logic [bdc_pkg::UPC_W-1:0] UPC_REDUCE = 3'd1;
  localparam logic [bdc_pkg::UPC_W-1:0] UPC_CHECK  = 3'd2;
  localparam logic [bdc_pkg::UPC_W-1:0] UPC_STEP   = 3'd3;
  localparam logic [bdc_pkg::UPC_W-1:0] UPC_EMIT   = 3'd4;

  logic [bdc_pkg::UPC_W-1:0] upc;
  logic [bdc_pkg::UPC_W-1:0] upc_next;
  bdc_pkg::ucode_t           word;
  logic                      taken;

  // Control store: op, branch condition, target if true, target if false
  function automatic bdc_pkg::ucode_t rom(input logic [bdc_pkg::UPC_W-1:0] a);
    bdc_pkg::ucode_t w;
    case (a)
      UPC_WAIT:   w = '{bdc_pkg::OP_LOAD,   bdc_pkg::COND_ACCEPT,   UPC_REDUCE, UPC_WAIT};
      UPC_REDUCE: w = '{bdc_pkg::OP_REDUCE, bdc_pkg::COND_REDUCED,  UPC_CHECK,  UPC_REDUCE};
      UPC_CHECK:  w = '{bdc_pkg::OP_CHECK,  bdc_pkg::COND_VALID,    UPC_STEP,   UPC_EMIT};
      UPC_STEP:   w = '{bdc_pkg::OP_STEP,   bdc_pkg::COND_IN_RANGE, UPC_STEP,   UPC_EMIT};
      UPC_EMIT:   w = '{bdc_pkg::OP_EMIT,   bdc_pkg::COND_OUT_FREE, UPC_WAIT,   UPC_EMIT};
      default:    w = '{bdc_pkg::OP_LOAD,   bdc_pkg::COND_ACCEPT,   UPC_WAIT,   UPC_WAIT};
    endcase
    return w;
  endfunction

  assign word = rom(upc);
  assign op   = word.op;

  // Branch condition select
  always_comb begin
    case (word.cond)
      bdc_pkg::COND_ACCEPT:   taken = flags.accept;
      bdc_pkg::COND_REDUCED:  taken = flags.reduced;
      bdc_pkg::COND_VALID:    taken = flags.valid;
      bdc_pkg::COND_IN_RANGE: taken = flags.in_range;
      bdc_pkg::COND_OUT_FREE: taken = flags.out_free;
      default:                taken = 1'b0;
    endcase
    upc_next = taken ? word.tgt_true : word.tgt_false;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bdc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdc_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bdc_pkg::op_t             op,
  output bdc_pkg::flags_t               flags,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [bdc_pkg::IN_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [bdc_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tuser
);

  // Date cursor (starts at the first date) and end bound
  logic [bdc_pkg::DAY_W-1:0]   cur_d;
  logic [bdc_pkg::MONTH_W-1:0] cur_m;
  logic [bdc_pkg::YEAR_W-1:0]  cur_y;
  logic [bdc_pkg::DAY_W-1:0]   end_d;
  logic [bdc_pkg::MONTH_W-1:0] end_m;
  logic [bdc_pkg::YEAR_W-1:0]  end_y;
  // Years reduced modulo 400
  logic [bdc_pkg::YEAR_W-1:0]  rem_s;
  logic [bdc_pkg::YEAR_W-1:0]  rem_e;
  logic [bdc_pkg::RES_W-1:0]   ymod;
  logic [2:0]                  wd;
  logic [bdc_pkg::CNT_W-1:0]   cnt;
  logic                        bad;
  // Output register
  logic [bdc_pkg::CNT_W-1:0]   out_cnt;
  logic                        out_bad;
  logic                        out_valid;

  logic                        accept;
  logic                        out_free;
  logic                        reduced;
  logic                        valid;
  logic                        in_range;
  logic [bdc_pkg::DAY_W-1:0]   dim_s;
  logic [bdc_pkg::DAY_W-1:0]   dim_e;
  logic [bdc_pkg::DAY_W-1:0]   dim_cur;
  logic                        a;
  logic [bdc_pkg::RES_W-1:0]   rsh;
  logic [1:0]                  rdiv;
  logic [bdc_pkg::VSUM_W-1:0]  vsum;
  logic [2:0]                  start_wd;

  assign s_tready = (op == bdc_pkg::OP_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // Date checks
  always_comb begin
    reduced  = (rem_s < bdc_pkg::YEAR_CYCLE) && (rem_e < bdc_pkg::YEAR_CYCLE);
    dim_s    = bdc_pkg::days_in_month(cur_m, bdc_pkg::is_leap(rem_s[bdc_pkg::RES_W-1:0]));
    dim_e    = bdc_pkg::days_in_month(end_m, bdc_pkg::is_leap(rem_e[bdc_pkg::RES_W-1:0]));
    valid    = (dim_s != '0) && (cur_d != '0) && (cur_d <= dim_s) &&
               (dim_e != '0) && (end_d != '0) && (end_d <= dim_e);
    in_range = {cur_y, cur_m, cur_d} < {end_y, end_m, end_d};
    dim_cur  = bdc_pkg::days_in_month(cur_m, bdc_pkg::is_leap(ymod));
  end

  // Start weekday; whole 400-year cycles drop out mod 7
  always_comb begin
    a = (cur_m < bdc_pkg::MONTH_MAR);
    if (a) begin
      rsh = (rem_s[bdc_pkg::RES_W-1:0] == '0) ? bdc_pkg::RES_LAST
                                                : rem_s[bdc_pkg::RES_W-1:0] - 1'b1;
    end else begin
      rsh = rem_s[bdc_pkg::RES_W-1:0];
    end
    if (rsh >= bdc_pkg::RES_W'(300)) begin
      rdiv = 2'd3;
    end else if (rsh >= bdc_pkg::RES_W'(200)) begin
      rdiv = 2'd2;
    end else if (rsh >= bdc_pkg::RES_W'(100)) begin
      rdiv = 2'd1;
    end else begin
      rdiv = 2'd0;
    end
    vsum = bdc_pkg::VSUM_W'(cur_d) + bdc_pkg::VSUM_W'(rsh) + bdc_pkg::VSUM_W'(rsh >> 2)
         - bdc_pkg::VSUM_W'(rdiv) + bdc_pkg::VSUM_W'(bdc_pkg::month_offset(cur_m));
    start_wd = bdc_pkg::mod7(vsum);
  end

  assign flags = '{accept: accept, reduced: reduced, valid: valid,
                   in_range: in_range, out_free: out_free};

  // Datapath registers, one operation per control word
  always_ff @(posedge clk) begin
    case (op)
      bdc_pkg::OP_LOAD: begin
        if (accept) begin
          cur_d <= s_tdata[4:0];
          cur_m <= s_tdata[8:5];
          cur_y <= s_tdata[22:9];
          end_d <= s_tdata[27:23];
          end_m <= s_tdata[31:28];
          end_y <= s_tdata[45:32];
          rem_s <= s_tdata[22:9];
          rem_e <= s_tdata[45:32];
        end
      end
      bdc_pkg::OP_REDUCE: begin
        if (rem_s >= bdc_pkg::YEAR_CYCLE) begin
          rem_s <= rem_s - bdc_pkg::YEAR_CYCLE;
        end
        if (rem_e >= bdc_pkg::YEAR_CYCLE) begin
          rem_e <= rem_e - bdc_pkg::YEAR_CYCLE;
        end
      end
      bdc_pkg::OP_CHECK: begin
        bad  <= !valid;
        cnt  <= '0;
        ymod <= rem_s[bdc_pkg::RES_W-1:0];
        wd   <= start_wd;
      end
      bdc_pkg::OP_STEP: begin
        if (in_range) begin
          // count working days, saturating
          if ((wd != bdc_pkg::WD_FRI) && (wd != bdc_pkg::WD_SAT) &&
              (cnt != bdc_pkg::COUNT_MAX)) begin
            cnt <= cnt + 1'b1;
          end
          wd <= (wd == bdc_pkg::WD_SAT) ? 3'd0 : wd + 1'b1;
          // advance one day with month and year rollover
          if (cur_d == dim_cur) begin
            cur_d <= bdc_pkg::DAY_W'(1);
            if (cur_m == bdc_pkg::MONTH_DEC) begin
              cur_m <= bdc_pkg::MONTH_W'(1);
              cur_y <= cur_y + 1'b1;
              ymod  <= (ymod == bdc_pkg::RES_LAST) ? '0 : ymod + 1'b1;
            end else begin
              cur_m <= cur_m + 1'b1;
            end
          end else begin
            cur_d <= cur_d + 1'b1;
          end
        end
      end
      bdc_pkg::OP_EMIT: begin
        if (out_free) begin
          out_cnt <= bad ? '0 : cnt;
          out_bad <= bad;
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((op == bdc_pkg::OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bdc_pkg::OUT_W'(out_cnt);
  assign m_tuser  = out_bad;

endmodule

`default_nettype wire

[hw/rtl/business_day_counter.sv]
// Each item runs load, modulo-400 reduction of both years, date check, the step loop over
//   the days of the range, and emit; a bad date skips the step loop. The block takes no
//   new item until the emit step has stored the previous result.
// The step loop advances one day per cycle; a stalled output adds its stall to the
//   emit step.
// A new item is taken while the previous result waits in the output register.
// Reset (rst, synchronous, active high) returns the sequencer to wait and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module business_day_counter (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, pad
  input  wire logic [bdc_pkg::IN_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // business_days, pad
  output logic [bdc_pkg::OUT_W-1:0]     m_tdata,
  // bad_date
  output logic                          m_tuser
);

  bdc_pkg::op_t    op;
  bdc_pkg::flags_t flags;

  bdc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  bdc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .flags    (flags),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/bdc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdc_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [bdc_pkg::OUT_W-1:0] m_tdata,
  input wire logic                      m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A bad date always reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad date with nonzero count");

  // Pad bits above the count stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[bdc_pkg::OUT_W-1:bdc_pkg::CNT_W] == '0)
    else $error("pad bits set");

  // Reset empties the output and the block is ready for an item right after
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output or input side wrong after reset");

  // No item is taken in the cycle right after one was taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind business_day_counter bdc_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
